/* design/ovn_pkg.sv */
// ----------------------------------------------------------------------------
// ovn_pkg: shared constants and types for the octave value-noise height core
// Holds the grid geometry, the datapath widths and the command and status
// structs that join the controller to the datapath.
// ----------------------------------------------------------------------------
package ovn_pkg;

  // Grid geometry: a WIDTH x WIDTH seed table, log2(WIDTH) octaves.
  localparam int unsigned WIDTH   = 256;
  localparam int unsigned CW      = 8;    // coordinate bits
  localparam int unsigned ADDR_W  = 2 * CW;
  localparam int unsigned OCT_W   = 3;
  localparam logic [OCT_W-1:0] OCT_LAST = 3'd7;

  // Datapath widths.
  localparam int unsigned SEED_W  = 8;
  localparam int unsigned MIX_W   = 16;   // one interpolated row
  localparam int unsigned SAMP_W  = 24;   // Q8.16 sample
  localparam int unsigned W_W     = 18;   // Q2.16 octave weight
  localparam int unsigned WSUM_W  = 21;
  localparam int unsigned PROD_W  = 42;
  localparam int unsigned ACC_W   = 45;
  localparam int unsigned DEN_W   = 30;
  localparam int unsigned Q_W     = 18;   // divider quotient
  localparam int unsigned H_W     = 16;
  localparam int unsigned BIAS_W  = 12;
  localparam int unsigned HR_W    = 9;

  localparam logic [W_W-1:0]    WEIGHT_ONE = 18'd65536;
  localparam logic [BIAS_W-1:0] BIAS_RST   = 12'd410;
  localparam logic [HR_W-1:0]   HR_RST     = 9'd128;

  // Configuration register indexes.
  localparam logic CFG_BIAS = 1'b0;
  localparam logic CFG_HR   = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic             wr_en;
    logic             start;
    logic             rd_en;
    logic [1:0]       corner;
    logic             mix1;
    logic             mix2;
    logic             mul;
    logic             acc;
    logic             wdiv_start;
    logic             w_load;
    logic             den;
    logic             fdiv_start;
    logic             h_load;
    logic [OCT_W-1:0] oct;
  } ovn_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic div_busy;
  } ovn_sts_t;

endpackage

/* design/ovn_div.sv */
// ----------------------------------------------------------------------------
// ovn_div: bit-serial restoring divider with saturation
// Produces an 18-bit quotient (weight mode) or a 16-bit quotient (height
// mode), one bit per cycle. A quotient that would not fit saturates to all
// ones of its width.
// ----------------------------------------------------------------------------
module ovn_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic                      height_mode,
  input  logic [ovn_pkg::ACC_W-1:0] num,
  input  logic [ovn_pkg::DEN_W-1:0] den,
  output logic                      busy,
  output logic [ovn_pkg::Q_W-1:0]   quot
);

  logic [ovn_pkg::DEN_W-1:0] rem_r, rem_nxt;
  logic [ovn_pkg::DEN_W-1:0] den_r, den_nxt;
  logic [ovn_pkg::Q_W-1:0]   low_r, low_nxt;
  logic [ovn_pkg::Q_W-1:0]   quot_r, quot_nxt;
  logic [4:0]                cnt_r, cnt_nxt;
  logic                      busy_r, busy_nxt;

  logic [47:0]               num_ext;
  logic                      sat;
  logic [ovn_pkg::DEN_W:0]   trial;
  logic                      ge;

  // Saturation test: the quotient does not fit when num >= den * 2^Q.
  assign num_ext = {3'd0, num};
  always_comb begin
    if (height_mode) begin
      sat = num_ext >= {2'd0, den, 16'd0};
    end else begin
      sat = num_ext >= {den, 18'd0};
    end
  end

  // One restoring step.
  assign trial = {rem_r, low_r[ovn_pkg::Q_W-1]};
  assign ge    = trial >= {1'b0, den_r};

  always_comb begin
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    low_nxt  = low_r;
    quot_nxt = quot_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    if (start) begin
      den_nxt  = den;
      quot_nxt = '0;
      if (height_mode) begin
        rem_nxt = {1'b0, num[44:16]};
        low_nxt = {num[15:0], 2'd0};
        cnt_nxt = 5'd16;
      end else begin
        rem_nxt = {3'd0, num[44:18]};
        low_nxt = num[17:0];
        cnt_nxt = 5'd18;
      end
      if (sat) begin
        quot_nxt = height_mode ? 18'h0FFFF : 18'h3FFFF;
        busy_nxt = 1'b0;
      end else begin
        busy_nxt = 1'b1;
      end
    end else if (busy_r) begin
      rem_nxt  = ge ? ovn_pkg::DEN_W'(trial - {1'b0, den_r})
                    : trial[ovn_pkg::DEN_W-1:0];
      low_nxt  = {low_r[ovn_pkg::Q_W-2:0], 1'b0};
      quot_nxt = {quot_r[ovn_pkg::Q_W-2:0], ge};
      cnt_nxt  = cnt_r - 5'd1;
      busy_nxt = (cnt_r != 5'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    den_r  <= den_nxt;
    low_r  <= low_nxt;
    quot_r <= quot_nxt;
  end

  assign busy = busy_r;
  assign quot = quot_r;

endmodule

/* design/ovn_dp.sv */
// ----------------------------------------------------------------------------
// ovn_dp: datapath of the octave value-noise height core
// Seed table, configuration registers, corner capture, bilinear mix,
// weighted accumulation and the shared divider.
// ----------------------------------------------------------------------------
module ovn_dp (
  input  logic                       clk,
  input  logic                       rst_n,
  input  ovn_pkg::ovn_cmd_t          cmd,
  output ovn_pkg::ovn_sts_t          sts,
  input  logic [ovn_pkg::CW-1:0]     in_x,
  input  logic [ovn_pkg::CW-1:0]     in_y,
  input  logic [ovn_pkg::SEED_W-1:0] in_seed_value,
  input  logic                       cfg_wr,
  input  logic                       cfg_index,
  input  logic [ovn_pkg::BIAS_W-1:0] cfg_data,
  output logic [ovn_pkg::H_W-1:0]    height
);

  // Configuration registers.
  logic [ovn_pkg::BIAS_W-1:0] bias_r;
  logic [ovn_pkg::HR_W-1:0]   hr_r;
  logic [ovn_pkg::BIAS_W-1:0] bias_eff;
  logic [ovn_pkg::HR_W-1:0]   hr_eff;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bias_r <= ovn_pkg::BIAS_RST;
      hr_r   <= ovn_pkg::HR_RST;
    end else if (cfg_wr) begin
      if (cfg_index == ovn_pkg::CFG_BIAS) begin
        bias_r <= cfg_data;
      end else begin
        hr_r <= cfg_data[ovn_pkg::HR_W-1:0];
      end
    end
  end

  // A zero divisor behaves as the smallest step.
  assign bias_eff = (bias_r == '0) ? ovn_pkg::BIAS_W'(1) : bias_r;
  assign hr_eff   = (hr_r == '0) ? ovn_pkg::HR_W'(1) : hr_r;

  // Query coordinates.
  logic [ovn_pkg::CW-1:0] x_r, y_r;

  // Octave geometry: pitch, offsets inside the cell and the cell corners.
  logic [ovn_pkg::CW:0]   pitch;
  logic [ovn_pkg::CW-1:0] mask;
  logic [ovn_pkg::CW-1:0] dx, dy, x1, y1, x2, y2;
  logic [ovn_pkg::CW:0]   pdx, pdy;

  assign pitch = (ovn_pkg::CW+1)'(ovn_pkg::WIDTH) >> cmd.oct;
  assign mask  = ovn_pkg::CW'(pitch - 9'd1);
  assign dx    = x_r & mask;
  assign dy    = y_r & mask;
  assign x1    = x_r & ~mask;
  assign y1    = y_r & ~mask;
  assign x2    = x1 + pitch[ovn_pkg::CW-1:0];
  assign y2    = y1 + pitch[ovn_pkg::CW-1:0];
  assign pdx   = pitch - {1'b0, dx};
  assign pdy   = pitch - {1'b0, dy};

  // Seed table: one port, written by write requests, read for corners.
  logic [ovn_pkg::SEED_W-1:0] mem [0:ovn_pkg::WIDTH*ovn_pkg::WIDTH-1];
  logic [ovn_pkg::SEED_W-1:0] mem_q_r;
  logic [ovn_pkg::ADDR_W-1:0] addr;

  always_comb begin
    case (cmd.corner)
      2'd0:    addr = {x1, y1};
      2'd1:    addr = {x2, y1};
      2'd2:    addr = {x1, y2};
      2'd3:    addr = {x2, y2};
      default: addr = {x1, y1};
    endcase
    if (cmd.wr_en) begin
      addr = {in_x, in_y};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[addr] <= in_seed_value;
    end
    if (cmd.rd_en) begin
      mem_q_r <= mem[addr];
    end
  end

  // Corner capture in the cycle after each read.
  logic                       rd_pend_r;
  logic [1:0]                 rd_tag_r;
  logic [ovn_pkg::SEED_W-1:0] seed_r [0:3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_pend_r <= 1'b0;
    end else begin
      rd_pend_r <= cmd.rd_en;
    end
  end

  always_ff @(posedge clk) begin
    rd_tag_r <= cmd.corner;
    if (rd_pend_r) begin
      seed_r[rd_tag_r] <= mem_q_r;
    end
  end

  // Horizontal mix of both corner rows.
  logic [ovn_pkg::MIX_W:0]   top_a, top_b, bot_a, bot_b;
  logic [ovn_pkg::MIX_W-1:0] top_r, bot_r;

  assign top_a = 17'(pdx) * 17'(seed_r[0]);
  assign top_b = 17'(dx) * 17'(seed_r[1]);
  assign bot_a = 17'(pdx) * 17'(seed_r[2]);
  assign bot_b = 17'(dx) * 17'(seed_r[3]);

  // Vertical mix and scaling to Q8.16 (divide by pitch squared).
  logic [ovn_pkg::SAMP_W:0]   v_a, v_b;
  logic [ovn_pkg::SAMP_W-1:0] v_sum;
  logic [37:0]                v_sh;
  logic [ovn_pkg::SAMP_W-1:0] sample_r;

  assign v_a   = 25'(pdy) * 25'(top_r);
  assign v_b   = 25'(dy) * 25'(bot_r);
  assign v_sum = ovn_pkg::SAMP_W'(v_a + v_b);
  assign v_sh  = {14'd0, v_sum} << {cmd.oct, 1'b0};

  // Weighting, accumulation and normalization.
  logic [ovn_pkg::W_W-1:0]    w_r;
  logic [ovn_pkg::WSUM_W-1:0] wsum_r;
  logic [ovn_pkg::PROD_W-1:0] prod_r;
  logic [ovn_pkg::ACC_W-1:0]  acc_r;
  logic [ovn_pkg::DEN_W-1:0]  den_r;
  logic [ovn_pkg::H_W-1:0]    height_r;

  logic                       div_start;
  logic                       div_busy;
  logic [ovn_pkg::ACC_W-1:0]  div_num;
  logic [ovn_pkg::DEN_W-1:0]  div_den;
  logic [ovn_pkg::Q_W-1:0]    div_quot;

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      x_r    <= in_x;
      y_r    <= in_y;
      w_r    <= ovn_pkg::WEIGHT_ONE;
      wsum_r <= '0;
      acc_r  <= '0;
    end
    if (cmd.mix1) begin
      top_r <= ovn_pkg::MIX_W'(top_a + top_b);
      bot_r <= ovn_pkg::MIX_W'(bot_a + bot_b);
    end
    if (cmd.mix2) begin
      sample_r <= v_sh[ovn_pkg::SAMP_W-1:0];
    end
    if (cmd.mul) begin
      prod_r <= ovn_pkg::PROD_W'(sample_r) * ovn_pkg::PROD_W'(w_r);
    end
    if (cmd.acc) begin
      acc_r  <= acc_r + ovn_pkg::ACC_W'(prod_r);
      wsum_r <= wsum_r + ovn_pkg::WSUM_W'(w_r);
    end
    if (cmd.w_load) begin
      w_r <= div_quot;
    end
    if (cmd.den) begin
      den_r <= ovn_pkg::DEN_W'(hr_eff) * ovn_pkg::DEN_W'(wsum_r);
    end
    if (cmd.h_load) begin
      height_r <= div_quot[ovn_pkg::H_W-1:0];
    end
  end

  // Shared divider: next octave weight, then the final height.
  assign div_start = cmd.wdiv_start | cmd.fdiv_start;
  assign div_num   = cmd.fdiv_start ? acc_r : {19'd0, w_r, 8'd0};
  assign div_den   = cmd.fdiv_start ? den_r : ovn_pkg::DEN_W'(bias_eff);

  ovn_div u_div (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (div_start),
    .height_mode (cmd.fdiv_start),
    .num         (div_num),
    .den         (div_den),
    .busy        (div_busy),
    .quot        (div_quot)
  );

  assign sts.div_busy = div_busy;
  assign height       = height_r;

endmodule

/* design/ovn_ctrl.sv */
// ----------------------------------------------------------------------------
// ovn_ctrl: controller of the octave value-noise height core
// Sequences the corner reads, mixing, accumulation and divisions of each
// octave, and owns the input and result handshakes.
// ----------------------------------------------------------------------------
module ovn_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_req_type,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  ovn_pkg::ovn_sts_t sts,
  output ovn_pkg::ovn_cmd_t cmd
);

  typedef enum logic [11:0] {
    S_IDLE = 12'b0000_0000_0001,
    S_RD   = 12'b0000_0000_0010,
    S_SEED = 12'b0000_0000_0100,
    S_MIX1 = 12'b0000_0000_1000,
    S_MIX2 = 12'b0000_0001_0000,
    S_MUL  = 12'b0000_0010_0000,
    S_ACC  = 12'b0000_0100_0000,
    S_WDIV = 12'b0000_1000_0000,
    S_DEN  = 12'b0001_0000_0000,
    S_FST  = 12'b0010_0000_0000,
    S_FDIV = 12'b0100_0000_0000,
    S_FIN  = 12'b1000_0000_0000
  } state_t;

  state_t                    state_r, state_nxt;
  logic [ovn_pkg::OCT_W-1:0] oct_r, oct_nxt;
  logic [1:0]                corner_r, corner_nxt;
  logic                      out_valid_r, out_valid_nxt;

  // New requests are taken only between queries.
  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt     = state_r;
    oct_nxt       = oct_r;
    corner_nxt    = corner_r;
    cmd           = '0;
    cmd.oct       = oct_r;
    cmd.corner    = corner_r;
    case (state_r)
      S_IDLE: begin
        cmd.wr_en = in_valid & ~in_req_type;
        if (in_valid && in_req_type) begin
          cmd.start  = 1'b1;
          oct_nxt    = '0;
          corner_nxt = '0;
          state_nxt  = S_RD;
        end
      end
      S_RD: begin
        cmd.rd_en  = 1'b1;
        corner_nxt = corner_r + 2'd1;
        if (corner_r == 2'd3) begin
          state_nxt = S_SEED;
        end
      end
      S_SEED: state_nxt = S_MIX1;
      S_MIX1: begin
        cmd.mix1  = 1'b1;
        state_nxt = S_MIX2;
      end
      S_MIX2: begin
        cmd.mix2  = 1'b1;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_ACC;
      end
      S_ACC: begin
        cmd.acc = 1'b1;
        if (oct_r == ovn_pkg::OCT_LAST) begin
          state_nxt = S_DEN;
        end else begin
          cmd.wdiv_start = 1'b1;
          state_nxt      = S_WDIV;
        end
      end
      S_WDIV: begin
        if (!sts.div_busy) begin
          cmd.w_load = 1'b1;
          oct_nxt    = oct_r + 3'd1;
          state_nxt  = S_RD;
        end
      end
      S_DEN: begin
        cmd.den   = 1'b1;
        state_nxt = S_FST;
      end
      S_FST: begin
        cmd.fdiv_start = 1'b1;
        state_nxt      = S_FDIV;
      end
      S_FDIV: begin
        if (!sts.div_busy) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        // Load the result register once the previous result has left.
        if (!out_valid_r || !out_stall) begin
          cmd.h_load = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Result valid flag.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.h_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      oct_r       <= '0;
      corner_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      oct_r       <= oct_nxt;
      corner_r    <= corner_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

/* design/octave_value_noise_height_core.sv */
// ----------------------------------------------------------------------------
// octave_value_noise_height_core: octave value-noise terrain height
// Stores a 256 x 256 table of 8-bit seeds; a query returns the Q8.16 mean
// of eight bilinear octaves weighted by powers of 256/bias, over height_range.
// ----------------------------------------------------------------------------
// Usage:
//   The in_ channel carries requests. A write request (in_req_type low)
//   stores in_seed_value at (in_x, in_y) and yields no result. A query
//   (in_req_type high) yields one height on the out_ channel. An entry
//   must be written before a query reads it.
//   For each octave a query reads its four corner seeds through the single
//   seed table port and mixes them; each of the first seven octaves then
//   runs a bit-serial weight division, and a final height division closes
//   the query. The divider yields one quotient bit per cycle. in_stall
//   stays high while a query is in flight.
//   The height waits in an output register; while out_stall holds it, the
//   block can still return to idle and take writes, and a finished query
//   waits until that register is free.
//   cfg_ writes set bias (index 0) and height_range (index 1); cfg_ready is
//   always high. Write them only while the block is idle.
//   Reset (rst_n low, synchronous) clears the control state and sets bias
//   to 410 and height_range to 128. The seed table is not cleared.
// ----------------------------------------------------------------------------
module octave_value_noise_height_core (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       in_req_type,
  input  logic [ovn_pkg::CW-1:0]     in_x,
  input  logic [ovn_pkg::CW-1:0]     in_y,
  input  logic [ovn_pkg::SEED_W-1:0] in_seed_value,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [ovn_pkg::H_W-1:0]    out_height,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic                       cfg_index,
  input  logic [ovn_pkg::BIAS_W-1:0] cfg_data
);

  ovn_pkg::ovn_cmd_t cmd;
  ovn_pkg::ovn_sts_t sts;

  assign cfg_ready = 1'b1;

  ovn_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_req_type (in_req_type),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .sts         (sts),
    .cmd         (cmd)
  );

  ovn_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .in_x          (in_x),
    .in_y          (in_y),
    .in_seed_value (in_seed_value),
    .cfg_wr        (cfg_valid & cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .height        (out_height)
  );

  // An accepted query keeps the input side busy in the next cycle.
  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_req_type) |=> in_stall)
    else $error("query accepted but block not busy");

  // A write request never makes the block busy.
  a_write_free: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && !in_req_type) |=> !in_stall)
    else $error("write request left block busy");

  // A new result appears only at the end of a query.
  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result raised without a query in flight");

  // The seed table is never written while a query is in flight.
  a_no_wr_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr_en |-> (!in_stall && !cmd.rd_en))
    else $error("seed write during a query");

endmodule

/* tb/tb_octave_value_noise_height_core.sv */
// ----------------------------------------------------------------------------
// tb_octave_value_noise_height_core: self-checking bench for the height core
// Writes every seed entry that a query can reach, then sends directed and
// random write and query requests under several bias and height_range
// settings and idle patterns. Every height is compared with a cycle-free
// octave model kept in a class.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

// Predicts heights from its own copy of the seed table and the registers.
class height_scoreboard;
  logic [7:0]      seeds [65536];
  logic [11:0]     bias_reg;
  logic [8:0]      range_reg;
  logic [15:0]     pending_heights [$];
  int              mismatches;

  function new();
    bias_reg   = 12'd410;
    range_reg  = 9'd128;
    mismatches = 0;
  endfunction

  function longint unsigned seed_at(int unsigned col, int unsigned row);
    return longint'(seeds[col * 256 + row]);
  endfunction

  // Weighted mean of eight bilinear octaves in Q8.16, divided by height_range.
  function logic [15:0] octave_height(int unsigned x, int unsigned y);
    longint unsigned weight, wsum, acc, b, hr, top, bot, v, sample, h;
    int unsigned p, dx, dy, x1, y1, x2, y2;
    weight = 65536;
    wsum   = 0;
    acc    = 0;
    b      = (bias_reg == 0) ? 1 : bias_reg;
    hr     = (range_reg == 0) ? 1 : range_reg;
    for (int n = 0; n < 8; n++) begin
      p  = 256 >> n;
      dx = x % p;
      dy = y % p;
      x1 = x - dx;
      y1 = y - dy;
      x2 = (x1 + p) % 256;
      y2 = (y1 + p) % 256;
      top = (p - dx) * seed_at(x1, y1) + dx * seed_at(x2, y1);
      bot = (p - dx) * seed_at(x1, y2) + dx * seed_at(x2, y2);
      v = (p - dy) * top + dy * bot;
      sample = (v << 16) / (longint'(p) * p);
      wsum += weight;
      acc += sample * weight;
      weight = (weight * 256) / b;
      if (weight > 262143) weight = 262143;
    end
    h = acc / (hr * wsum);
    return (h > 65535) ? 16'hFFFF : h[15:0];
  endfunction

  // Records an accepted request: a write updates the table, a query
  // queues its expected height.
  function void note_request(logic rt, logic [7:0] x, logic [7:0] y, logic [7:0] s);
    if (!rt) begin
      seeds[{x, y}] = s;
    end else begin
      pending_heights.push_back(octave_height(x, y));
    end
  endfunction

  function void check_height(logic [15:0] got);
    logic [15:0] want;
    if (pending_heights.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("Unexpected height %0d", got);
      return;
    end
    want = pending_heights.pop_front();
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10) $display("Height mismatch: expected %0d, got %0d", want, got);
    end
  endfunction
endclass

module tb_octave_value_noise_height_core;

  localparam int LIMIT = 4000000;

  // Every corner coordinate read by a query whose x and y lie in 0..3 or
  // 252..255. Writing all pairs of these covers every entry such a query reads.
  localparam logic [7:0] LATTICE [14] = '{8'd0, 8'd2, 8'd4, 8'd8, 8'd16, 8'd32,
                                          8'd64, 8'd128, 8'd192, 8'd224, 8'd240,
                                          8'd248, 8'd252, 8'd254};

  logic                       clk;
  logic                       rst_n;
  logic                       in_valid;
  logic                       in_stall;
  logic                       in_req_type;
  logic [ovn_pkg::CW-1:0]     in_x;
  logic [ovn_pkg::CW-1:0]     in_y;
  logic [ovn_pkg::SEED_W-1:0] in_seed_value;
  logic                       out_valid;
  logic                       out_stall;
  logic [ovn_pkg::H_W-1:0]    out_height;
  logic                       cfg_valid;
  logic                       cfg_ready;
  logic                       cfg_index;
  logic [ovn_pkg::BIAS_W-1:0] cfg_data;

  height_scoreboard sb;
  int send_idle_pct;
  int recv_stall_pct;
  int cycles;

  octave_value_noise_height_core u_top (.*);

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Result side: check accepted heights, stall at random, watch the limit.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      if (rst_n && out_valid && !out_stall) sb.check_height(out_height);
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Query coordinate near a grid corner: 0..3 or 252..255.
  function automatic logic [7:0] query_coord();
    logic [2:0] v;
    v = 3'($urandom_range(7));
    return v[2] ? (8'd252 + {6'd0, v[1:0]}) : {6'd0, v[1:0]};
  endfunction

  // Sends one request, with random idle cycles first, and waits for it.
  task automatic send_request(logic rt, logic [7:0] x, logic [7:0] y, logic [7:0] s);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_req_type   <= rt;
    in_x          <= x;
    in_y          <= y;
    in_seed_value <= s;
    do @(posedge clk); while (in_stall);
    sb.note_request(rt, x, y, s);
  endtask

  // Waits for every height, lets the core settle, then writes a register.
  task automatic write_register(logic idx, logic [11:0] data);
    in_valid <= 1'b0;
    while (sb.pending_heights.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == ovn_pkg::CFG_BIAS) sb.bias_reg = data;
    else sb.range_reg = data[8:0];
  endtask

  // Random mix: queries near the corners, writes to the lattice or anywhere.
  task automatic random_burst(int count);
    logic       rt;
    logic [7:0] x, y;
    for (int i = 0; i < count; i++) begin
      rt = 1'($urandom_range(1));
      if (rt) begin
        x = query_coord();
        y = query_coord();
      end else if ($urandom_range(1) == 0) begin
        x = LATTICE[4'($urandom_range(13))];
        y = LATTICE[4'($urandom_range(13))];
      end else begin
        x = 8'($urandom_range(255));
        y = 8'($urandom_range(255));
      end
      send_request(rt, x, y, 8'($urandom_range(255)));
    end
  endtask

  // Main sequence.
  initial begin
    int bias_set [8]  = '{410, 1, 4095, 0, 256, 128, 2000, 300};
    int range_set [8] = '{128, 1, 256, 0, 511, 255, 64, 200};
    sb             = new();
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_req_type    = 1'b0;
    in_x           = '0;
    in_y           = '0;
    in_seed_value  = '0;
    out_stall      = 1'b0;
    cfg_valid      = 1'b0;
    cfg_index      = ovn_pkg::CFG_BIAS;
    cfg_data       = '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    cycles         = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Write every lattice entry so no query ever reads an unwritten entry.
    for (int i = 0; i < 14; i++) begin
      for (int j = 0; j < 14; j++) begin
        send_request(1'b0, LATTICE[i], LATTICE[j], 8'($urandom_range(255)));
      end
    end

    // Directed: extreme seeds and corners, wrapping at the grid edge.
    send_request(1'b1, 8'd0, 8'd0, 8'd0);
    send_request(1'b1, 8'd255, 8'd255, 8'd255);
    send_request(1'b0, 8'd255, 8'd255, 8'd255);
    send_request(1'b0, 8'd0, 8'd0, 8'd0);
    send_request(1'b1, 8'd255, 8'd0, 8'd170);
    send_request(1'b1, 8'd0, 8'd255, 8'd85);
    send_request(1'b1, 8'd2, 8'd253, 8'd0);
    send_request(1'b1, 8'd253, 8'd2, 8'd0);
    send_request(1'b1, 8'd255, 8'd255, 8'd0);
    for (int k = 0; k < 4; k++) send_request(1'b0, 8'd0, 8'(k * 64), 8'd255);
    send_request(1'b1, 8'd0, 8'd1, 8'd0);

    // Sweep register settings and idle patterns.
    for (int c = 0; c < 8; c++) begin
      write_register(ovn_pkg::CFG_BIAS, 12'(bias_set[c]));
      write_register(ovn_pkg::CFG_HR, 12'(range_set[c]));
      if (c == 1) begin
        // Large seeds with a unit range drive the height into saturation.
        send_request(1'b1, 8'd255, 8'd255, 8'd0);
        send_request(1'b1, 8'd0, 8'd0, 8'd0);
      end
      for (int ph = 0; ph < 4; ph++) begin
        send_idle_pct  = (ph == 1) ? 59 : (ph == 3) ? 33 : 0;
        recv_stall_pct = (ph == 2) ? 59 : (ph == 3) ? 33 : 0;
        random_burst(45);
      end
    end

    in_valid <= 1'b0;
    while (sb.pending_heights.size() != 0) @(posedge clk);
    recv_stall_pct = 0;
    repeat (300) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending_heights.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule

/* filelist.f */
design/ovn_pkg.sv
design/ovn_div.sv
design/ovn_dp.sv
design/ovn_ctrl.sv
design/octave_value_noise_height_core.sv
tb/tb_octave_value_noise_height_core.sv
